/* hdl/rmsq_pkg.sv */
// shared types and constants of the rms norm int8 quantizer
`timescale 1ns / 1ps
package rmsq_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int GAIN_WIDTH = 16;
   localparam int MAX_COLS = 4096;
   localparam int EPS_WIDTH = 16;
   localparam int SCALE_WIDTH = 32;
   localparam int QUANT_WIDTH = 8;
   localparam int STATUS_WIDTH = 2;

   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd168;
   localparam logic [QUANT_WIDTH-1:0] QMAX = 8'd127;
   localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = 32'h0001_0000;
   localparam logic [SCALE_WIDTH-1:0] SCALE_SAT = 32'hFFFF_FFFF;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd2;

   localparam logic [1:0] REG_EPSILON = 2'd0;

   typedef struct packed {
      logic action;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic signed [GAIN_WIDTH-1:0] gain;
      logic last_element;
   } req_type;

   typedef struct packed {
      logic signed [QUANT_WIDTH-1:0] quantized;
      logic [SCALE_WIDTH-1:0] scale;
      logic last_of_row;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_type;

endpackage

/* hdl/rmsq_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rmsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic clock,
   input  logic we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/rmsq_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rmsq_div #(
   parameter int W = 54
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic done,
   output logic [W-1:0] quo
);

   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] den_ff, den_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W:0] shifted;
   logic ge;

   always_comb begin
      shifted = {rem_ff, num_ff[W-1]};
      ge = shifted >= {1'b0, den_ff};
      rem_in = rem_ff;
      num_in = num_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         num_in = num;
         den_in = den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? W'(shifted - {1'b0, den_ff}) : shifted[W-1:0];
         num_in = {num_ff[W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo = num_ff;

endmodule

/* hdl/rmsnorm_int8_quantizer_unit.sv */
// rms norm with symmetric int8 quantization, top level
// a load is accepted back to back; a closing load stalls the input through the mean
// division, the root and the scale division (DW = 54); a zero peak ends it after the mean
// a drain stalls the input until its response is sent, using the shared bit-serial divider
// synchronous active-high reset clears row state, scale to zero, epsilon to 168
`timescale 1ns / 1ps
module rmsnorm_int8_quantizer_unit #(
   parameter int MAX_COLS = rmsq_pkg::MAX_COLS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rmsq_pkg::req_type req_item,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rmsq_pkg::rsp_type rsp_item,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   localparam int SW = rmsq_pkg::SAMPLE_WIDTH;
   localparam int GW = rmsq_pkg::GAIN_WIDTH;
   localparam int PW = SW + GW;
   localparam int MW = SW + GW - 1;
   localparam int SQMW = 2 * SW - 1;
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SUMW = SQMW + CW;
   localparam int SQW = 2 * ((SUMW + 10) / 2);
   localparam int RW = SQW / 2;
   localparam int IW = $clog2(RW + 1);
   localparam int DA = (SQW > MW + 10) ? SQW : MW + 10;
   localparam int DW = (DA > RW + 9) ? DA : RW + 9;
   localparam int EW = rmsq_pkg::EPS_WIDTH;
   localparam int SCW = rmsq_pkg::SCALE_WIDTH;
   localparam int QW = rmsq_pkg::QUANT_WIDTH;
   localparam int STW = rmsq_pkg::STATUS_WIDTH;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MEAN  = 8'b0000_0010,
      S_SQRT  = 8'b0000_0100,
      S_ROOT  = 8'b0000_1000,
      S_SCALE = 8'b0001_0000,
      S_RD    = 8'b0010_0000,
      S_QDIV  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [EW-1:0] eps_ff, eps_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [MW-1:0] peak_ff, peak_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic ready_ff, ready_in;
   logic ovf_ff, ovf_in;
   logic [SCW-1:0] scale_ff, scale_in;
   logic [SQW-1:0] v_ff, v_in;
   logic [SQW-1:0] res_ff, res_in;
   logic [SQW-1:0] bit_ff, bit_in;
   logic [IW-1:0] it_ff, it_in;
   logic neg_ff, neg_in;
   rmsq_pkg::rsp_type pend_ff, pend_in;
   rmsq_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic req_take, cfg_write;
   logic [CW-1:0] c0;
   logic [SUMW-1:0] s0;
   logic [MW-1:0] p0;
   logic signed [PW-1:0] prod;
   logic [PW-1:0] prod_abs;
   logic [SW-1:0] sm;
   logic [2*SW-1:0] sq;
   logic ram_we;
   logic [PW-1:0] ram_rdata;
   logic signed [PW-1:0] rp;
   logic [PW-1:0] rp_abs;
   logic [MW-1:0] rmag;
   logic [SQW-1:0] trial;
   logic [SUMW:0] ms;
   logic [DW-1:0] den_s;
   logic div_start, div_done;
   logic [DW-1:0] div_num, div_den, div_quo;
   logic [QW-1:0] qmag;

   assign req_take = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign cfg_write = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = {{(32 - EW){1'b0}}, eps_ff};

   assign prod = req_item.sample * req_item.gain;
   assign prod_abs = prod[PW-1] ? PW'(-prod) : prod;
   assign sm = req_item.sample[SW-1] ? SW'(-req_item.sample) : req_item.sample;
   assign sq = sm * sm;
   assign rp = ram_rdata;
   assign rp_abs = rp[PW-1] ? PW'(-rp) : rp;
   assign rmag = rp_abs[MW-1:0];
   assign trial = res_ff + bit_ff;
   assign den_s = (DW'(res_ff[RW-1:0]) << 7) - DW'(res_ff[RW-1:0]);
   assign qmag = (div_quo > DW'(rmsq_pkg::QMAX)) ? rmsq_pkg::QMAX : div_quo[QW-1:0];

   rmsq_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(c0[AW-1:0]),
      .wdata(prod),
      .raddr(rd_ff[AW-1:0]),
      .rdata(ram_rdata)
   );

   rmsq_div #(.W(DW)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .quo(div_quo)
   );

   always_comb begin
      state_in = state_ff;
      eps_in = cfg_write ? pwdata[EW-1:0] : eps_ff;
      sum_in = sum_ff;
      peak_in = peak_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      ready_in = ready_ff;
      ovf_in = ovf_ff;
      scale_in = scale_ff;
      v_in = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      it_in = it_ff;
      neg_in = neg_ff;
      pend_in = pend_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we = 1'b0;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      ms = '0;
      c0 = ready_ff ? '0 : cnt_ff;
      s0 = ready_ff ? '0 : sum_ff;
      p0 = ready_ff ? '0 : peak_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take && req_item.action == rmsq_pkg::ACT_LOAD) begin
               sum_in = s0;
               peak_in = p0;
               cnt_in = c0;
               if (ready_ff) begin
                  ready_in = 1'b0;
                  ovf_in = 1'b0;
                  rd_in = '0;
               end
               if (c0 < CW'(MAX_COLS)) begin
                  ram_we = 1'b1;
                  cnt_in = c0 + 1'b1;
                  sum_in = s0 + SUMW'(sq[SQMW-1:0]);
                  if (prod_abs[MW-1:0] > p0) begin
                     peak_in = prod_abs[MW-1:0];
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.last_element) begin
                  div_start = 1'b1;
                  div_num = DW'(sum_in);
                  div_den = DW'(cnt_in);
                  state_in = S_MEAN;
               end
            end else if (req_take) begin
               if (!ready_ff || rd_ff >= cnt_ff) begin
                  pend_in.quantized = '0;
                  pend_in.scale = '0;
                  pend_in.last_of_row = 1'b0;
                  pend_in.status = rmsq_pkg::ST_EMPTY;
                  state_in = S_OUT;
               end else begin
                  rd_in = rd_ff + 1'b1;
                  pend_in.scale = scale_ff;
                  pend_in.last_of_row = (rd_in == cnt_ff);
                  pend_in.status = ovf_ff ? rmsq_pkg::ST_OVERFLOW : rmsq_pkg::ST_OK;
                  state_in = S_RD;
               end
            end
         end
         S_MEAN: begin
            if (div_done) begin
               if (peak_ff == '0) begin
                  scale_in = rmsq_pkg::SCALE_ONE;
                  ready_in = 1'b1;
                  rd_in = '0;
                  state_in = S_IDLE;
               end else begin
                  ms = {1'b0, div_quo[SUMW-1:0]} + (SUMW + 1)'(eps_ff);
                  v_in = SQW'(ms) << 8;
                  res_in = '0;
                  bit_in = SQW'(1) << (SQW - 2);
                  it_in = '0;
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            it_in = it_ff + 1'b1;
            if (it_ff == IW'(RW - 1)) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (res_ff == '0) begin
               scale_in = rmsq_pkg::SCALE_SAT;
               ready_in = 1'b1;
               rd_in = '0;
               state_in = S_IDLE;
            end else begin
               div_start = 1'b1;
               div_num = (DW'(peak_ff) << 9) + den_s;
               div_den = den_s << 1;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (div_done) begin
               scale_in = (|(div_quo >> SCW)) ? rmsq_pkg::SCALE_SAT : div_quo[SCW-1:0];
               ready_in = 1'b1;
               rd_in = '0;
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            neg_in = rp[PW-1];
            if (ovf_ff || peak_ff == '0) begin
               pend_in.quantized = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_num = (DW'(rmag) << 8) - (DW'(rmag) << 1) + DW'(peak_ff);
               div_den = DW'(peak_ff) << 1;
               state_in = S_QDIV;
            end
         end
         S_QDIV: begin
            if (div_done) begin
               pend_in.quantized = neg_ff ? QW'(-qmag) : qmag;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = pend_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eps_ff <= rmsq_pkg::EPS_RESET;
         sum_ff <= '0;
         peak_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= '0;
         ready_ff <= 1'b0;
         ovf_ff <= 1'b0;
         scale_ff <= '0;
         it_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         eps_ff <= eps_in;
         sum_ff <= sum_in;
         peak_ff <= peak_in;
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         ready_ff <= ready_in;
         ovf_ff <= ovf_in;
         scale_ff <= scale_in;
         it_ff <= it_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      neg_ff <= neg_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule
